// File: design/trd_pkg.sv
// Shared types, constants and the effect conversion function of the track row decoder.
package trd_pkg;

  localparam int unsigned DefMaxRows = 256;
  localparam int unsigned CfgW       = 9;
  localparam int unsigned CfgReset   = 64;

  // Token kinds in the low two bits of a byte
  localparam logic [1:0] TokSkip  = 2'd0;
  localparam logic [1:0] TokRun   = 2'd1;
  localparam logic [1:0] TokCopy  = 2'd2;
  localparam logic [1:0] TokEvent = 2'd3;

  // Source effect numbers
  localparam logic [7:0] EffPortaUp   = 8'h01;
  localparam logic [7:0] EffPortaDn   = 8'h02;
  localparam logic [7:0] EffTonePorta = 8'h03;
  localparam logic [7:0] EffVibrato   = 8'h04;
  localparam logic [7:0] EffArpeggio  = 8'h05;
  localparam logic [7:0] EffSpdTempo  = 8'h07;
  localparam logic [7:0] EffPan       = 8'h08;
  localparam logic [7:0] EffJump      = 8'h0B;
  localparam logic [7:0] EffGlobVol   = 8'h0C;
  localparam logic [7:0] EffBreak     = 8'h0D;
  localparam logic [7:0] EffExt       = 8'h0E;
  localparam logic [7:0] EffSpeed     = 8'h0F;
  localparam logic [7:0] EffVolSldA   = 8'h10;
  localparam logic [7:0] EffVolSldB   = 8'h20;
  localparam logic [7:0] EffRetrig    = 8'h30;
  localparam logic [7:0] EffTremolo   = 8'h40;
  localparam logic [7:0] EffTremor    = 8'h50;
  localparam logic [7:0] EffOffset    = 8'hEF;

  // Output command codes
  localparam logic [4:0] CodeNone     = 5'd0;
  localparam logic [4:0] CodeSpeed    = 5'd6;
  localparam logic [4:0] CodeTempo    = 5'd7;
  localparam logic [4:0] CodePan      = 5'd8;
  localparam logic [4:0] CodeJump     = 5'd9;
  localparam logic [4:0] CodeGlobVol  = 5'd10;
  localparam logic [4:0] CodeBreak    = 5'd11;
  localparam logic [4:0] CodeExt      = 5'd12;
  localparam logic [4:0] CodePanSld   = 5'd13;
  localparam logic [4:0] CodeRetrig   = 5'd14;
  localparam logic [4:0] CodeGvSld    = 5'd15;
  localparam logic [4:0] CodeVolSld   = 5'd16;
  localparam logic [4:0] CodeTremolo  = 5'd17;
  localparam logic [4:0] CodeTremor   = 5'd18;
  localparam logic [4:0] CodeOffset   = 5'd19;

  typedef struct packed {
    logic [7:0] note;
    logic [7:0] instrument;
    logic       has_volume;
    logic [6:0] volume;
    logic [4:0] effect_code;
    logic [7:0] effect_param;
  } cell_t;

  localparam int unsigned CellW = $bits(cell_t);

  typedef struct packed {
    logic       hit;
    logic [4:0] code;
    logic [7:0] param;
  } conv_t;

  // Controller to datapath
  typedef struct packed {
    logic accept;
    logic rd;
    logic emit_mem;
    logic emit_evt;
  } trd_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic go_read;
    logic go_evt;
    logic row_last;
    logic out_free;
  } trd_sts_t;

  // Convert one source effect into a command code and parameter
  function automatic conv_t trd_conv(logic [7:0] eff, logic [11:0] data);
    conv_t      r;
    logic [11:0] p;
    logic [4:0] code;
    logic [7:0] d;
    logic [5:0] q;
    logic [3:0] qs;
    d    = data[7:0];
    p    = data;
    code = CodeNone;
    q    = d[7:2];
    qs   = (q > 6'h0F) ? 4'hF : q[3:0];
    unique case (eff)
      EffPortaUp, EffPortaDn, EffTonePorta, EffVibrato, EffArpeggio: code = eff[4:0];
      EffSpdTempo: code = (data < 12'h020) ? CodeSpeed : CodeTempo;
      EffPan: begin
        code = CodePan;
        p    = {data[10:0], 1'b0};
      end
      EffJump:    code = CodeJump;
      EffGlobVol: code = CodeGlobVol;
      EffBreak: begin
        code = CodeBreak;
        p    = 12'({4'h0, d[3:0]}) + 12'({d[7:4], 3'b000}) + 12'({d[7:4], 1'b0});
      end
      EffExt: begin
        code = CodeExt;
        unique case (d[7:4])
          4'h0: code = CodeNone;
          4'h1: begin
            if (d[3:0] != 4'h0) begin
              p    = {4'h0, d | 8'hF0};
              code = CodePanSld;
            end else begin
              code = CodeNone;
            end
          end
          4'h2: begin
            if (d[3:0] != 4'h0) begin
              p    = {4'h0, d[3:0], 4'hF};
              code = CodePanSld;
            end else begin
              code = CodeNone;
            end
          end
          4'h3: p = {4'h0, 4'h1, d[3:0]};
          4'h4: p = {4'h0, 4'h3, d[3:0]};
          4'h6: p = {4'h0, 4'hB, d[3:0]};
          4'h7: p = {4'h0, 4'h4, d[3:0]};
          4'h9: begin
            code = CodeRetrig;
            p    = {8'h00, d[3:0]};
          end
          4'hA: begin
            code = CodeGvSld;
            p    = {4'h0, d[3:0], 4'h0};
          end
          4'hB: begin
            code = CodeGvSld;
            p    = {8'h00, d[3:0]};
          end
          4'hF: p = {4'h0, 4'hA, data[11:8]};
          default: p = data;
        endcase
      end
      EffSpeed: code = CodeSpeed;
      EffVolSldA: begin
        if (d[7:4] != 4'hE) begin
          code = CodeVolSld;
          if (d[7:4] == 4'hF) p = {4'h0, d[3:0], 4'hF};
          else p = {4'h0, qs, 4'h0};
        end
      end
      EffVolSldB: begin
        if (d[7:4] != 4'hE) begin
          code = CodeVolSld;
          if (d[7:4] != 4'hF) p = {8'h00, qs};
        end
      end
      EffRetrig:  code = CodeRetrig;
      EffTremolo: code = CodeTremolo;
      EffTremor:  code = CodeTremor;
      EffOffset: begin
        code = CodeOffset;
        if (data > 12'h0FF) p = 12'h0FF;
      end
      default: code = CodeNone;
    endcase
    r.hit   = (code != CodeNone);
    r.code  = code;
    r.param = p[7:0];
    return r;
  endfunction

endpackage

// File: design/trd_ram.sv
// Generic single write port, single read port RAM with registered read data.
module trd_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                                   clk_i,
  input  logic                                   we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                       wdata_i,
  input  logic                                   re_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                       rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: design/trd_ctrl.sv
// Controller state machine: byte intake, row read/write sequencing and event emission.
module trd_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              s_tvalid_i,
  output logic              s_tready_o,
  input  trd_pkg::trd_sts_t sts_i,
  output trd_pkg::trd_cmd_t cmd_o
);
  import trd_pkg::*;

  typedef enum logic [1:0] {
    S_IN,
    S_RD,
    S_WR,
    S_EVT
  } state_e;

  state_e state_q;

  // command decode
  always_comb begin
    cmd_o      = '0;
    s_tready_o = (state_q == S_IN);
    unique case (state_q)
      S_IN:  cmd_o.accept   = s_tvalid_i;
      S_RD:  cmd_o.rd       = 1'b1;
      S_WR:  cmd_o.emit_mem = sts_i.out_free;
      S_EVT: cmd_o.emit_evt = sts_i.out_free;
      default: cmd_o = '0;
    endcase
  end

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IN;
    end else begin
      unique case (state_q)
        S_IN: begin
          if (s_tvalid_i) begin
            if (sts_i.go_read) state_q <= S_RD;
            else if (sts_i.go_evt) state_q <= S_EVT;
          end
        end
        S_RD: state_q <= S_WR;
        S_WR: begin
          if (sts_i.out_free) state_q <= sts_i.row_last ? S_IN : S_RD;
        end
        S_EVT: begin
          if (sts_i.out_free) state_q <= S_IN;
        end
        default: state_q <= S_IN;
      endcase
    end
  end

endmodule

// File: design/trd_dp.sv
// Datapath: token decode, event gathering, cell store, row counter and output register.
module trd_dp #(
  parameter int unsigned MAX_ROWS = trd_pkg::DefMaxRows
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic [trd_pkg::CfgW-1:0] rows_in_pattern_i,
  input  logic [7:0]               data_byte_i,
  input  logic                     track_start_i,
  input  trd_pkg::trd_cmd_t        cmd_i,
  output trd_pkg::trd_sts_t        sts_o,
  input  logic                     m_tready_i,
  output logic                     m_tvalid_o,
  output logic [7:0]               row_index_o,
  output trd_pkg::cell_t           cell_o,
  output logic                     last_o
);
  import trd_pkg::*;

  localparam int unsigned AW   = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int unsigned RC_W = $clog2(MAX_ROWS + 1);
  localparam int unsigned LW   = (RC_W > CfgW) ? RC_W : CfgW;

  logic [RC_W-1:0]   rc_q;
  logic [RC_W-1:0]   src_q;
  logic              copy_q;
  logic [6:0]        rem_q;
  logic [5:0]        pend_q;
  logic [7:0]        ev_note_q, ev_inst_q, ev_vol_q, ev_cmd_q, ev_pf_q, ev_ps_q;
  logic [MAX_ROWS-1:0] vld_q;
  logic              rvld_q;
  logic              out_vld_q;
  logic [7:0]        out_row_q;
  cell_t             out_cell_q;
  logic              out_last_q;

  logic [LW-1:0]     lim, rc_w, rc_eff;
  logic [5:0]        pend_eff, pend_nxt;
  logic [5:0]        xx;
  logic              in_event, tok_ok;
  logic [LW:0]       skip_sum;
  logic [AW-1:0]     raddr, waddr;
  logic [RC_W-1:0]   run_src;
  cell_t             rd_cell, evt_cell, emit_cell;
  logic [CellW-1:0]  rdata;
  logic              emit;

  // row limit and token decode
  always_comb begin
    lim      = (LW'(rows_in_pattern_i) > LW'(MAX_ROWS)) ? LW'(MAX_ROWS)
                                                        : LW'(rows_in_pattern_i);
    rc_w     = LW'(rc_q);
    rc_eff   = track_start_i ? '0 : rc_w;
    pend_eff = track_start_i ? 6'd0 : pend_q;
    pend_nxt = pend_eff & (pend_eff - 6'd1);
    xx       = data_byte_i[7:2];
    in_event = (pend_eff != 6'd0);
    tok_ok   = !in_event && (rc_eff < lim);
    skip_sum = (LW + 1)'(rc_eff) + (LW + 1)'(xx) + (LW + 1)'(1);
  end

  // status toward the controller
  always_comb begin
    sts_o.go_read  = tok_ok && ((data_byte_i[1:0] == TokRun) ||
                                (data_byte_i[1:0] == TokCopy));
    sts_o.go_evt   = (in_event && (pend_nxt == 6'd0) && (rc_eff < lim)) ||
                     (tok_ok && (data_byte_i[1:0] == TokEvent) && (xx == 6'd0));
    sts_o.row_last = (rem_q == 7'd1) || ((rc_w + LW'(1)) >= lim);
    sts_o.out_free = !out_vld_q || m_tready_i;
  end

  // event cell conversion
  always_comb begin
    logic [7:0]  c1, c2;
    logic [11:0] p1, p2;
    conv_t       r1, r2;
    logic        allow2;
    c1 = {4'h0, ev_cmd_q[3:0]};
    c2 = {ev_cmd_q[7:4], 4'h0};
    p1 = {4'h0, ev_pf_q};
    p2 = {4'h0, ev_ps_q};
    if ((c1 == EffExt) && (ev_pf_q[7:4] == 4'hF) && (c2 == 8'h00)) begin
      c1 = EffOffset;
      p1 = {ev_pf_q[3:0], ev_ps_q};
      p2 = 12'h000;
    end
    r1     = trd_conv(c1, p1);
    r2     = trd_conv(c2, p2);
    allow2 = !(r1.hit && ((r1.code == CodeSpeed) || (r1.code == CodeTempo) ||
                          (r1.code == CodeBreak)));
    evt_cell            = '0;
    evt_cell.note       = ev_note_q;
    evt_cell.instrument = ev_inst_q;
    if (ev_vol_q != 8'h00) begin
      evt_cell.has_volume = 1'b1;
      evt_cell.volume     = 7'((9'(ev_vol_q) + 9'd1) >> 2);
    end
    if (allow2 && r2.hit) begin
      evt_cell.effect_code  = r2.code;
      evt_cell.effect_param = r2.param;
    end else if (r1.hit) begin
      evt_cell.effect_code  = r1.code;
      evt_cell.effect_param = r1.param;
    end
  end

  // store addressing
  always_comb begin
    run_src   = (rc_q != '0) ? (rc_q - RC_W'(1)) : rc_q;
    raddr     = copy_q ? src_q[AW-1:0] : run_src[AW-1:0];
    waddr     = rc_q[AW-1:0];
    rd_cell   = rvld_q ? cell_t'(rdata) : '0;
    emit      = cmd_i.emit_mem || cmd_i.emit_evt;
    emit_cell = cmd_i.emit_evt ? evt_cell : rd_cell;
  end

  trd_ram #(
    .WIDTH(CellW),
    .DEPTH(MAX_ROWS)
  ) u_store (
    .clk_i  (clk_i),
    .we_i   (emit),
    .waddr_i(waddr),
    .wdata_i(emit_cell),
    .re_i   (cmd_i.rd),
    .raddr_i(raddr),
    .rdata_o(rdata)
  );

  // control registers: row count, run state, event flags, valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rc_q   <= '0;
      src_q  <= '0;
      copy_q <= 1'b0;
      rem_q  <= '0;
      pend_q <= '0;
      vld_q  <= '0;
      rvld_q <= 1'b0;
    end else begin
      if (cmd_i.accept) begin
        if (track_start_i) begin
          vld_q  <= '0;
          rc_q   <= '0;
          pend_q <= '0;
        end
        if (in_event) begin
          pend_q <= pend_nxt;
        end else if (tok_ok) begin
          unique case (data_byte_i[1:0])
            TokRun: begin
              copy_q <= 1'b0;
              rem_q  <= 7'(xx) + 7'd1;
            end
            TokCopy: begin
              copy_q <= 1'b1;
              rem_q  <= 7'd1;
              src_q  <= (LW'(xx) < rc_eff) ? RC_W'(xx) : RC_W'(rc_eff);
            end
            TokEvent: pend_q <= xx;
            default: rc_q <= (skip_sum > (LW + 1)'(lim)) ? RC_W'(lim) : RC_W'(skip_sum);
          endcase
        end
      end
      if (cmd_i.rd) begin
        rvld_q <= vld_q[raddr];
      end
      if (emit) begin
        vld_q[waddr] <= 1'b1;
        rc_q         <= rc_q + RC_W'(1);
        rem_q        <= rem_q - 7'd1;
      end
    end
  end

  // event byte gathering
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ev_note_q <= '0;
      ev_inst_q <= '0;
      ev_vol_q  <= '0;
      ev_cmd_q  <= '0;
      ev_pf_q   <= '0;
      ev_ps_q   <= '0;
    end else if (cmd_i.accept) begin
      if (in_event) begin
        priority if (pend_eff[0]) ev_note_q <= data_byte_i;
        else if (pend_eff[1]) ev_inst_q <= data_byte_i;
        else if (pend_eff[2]) ev_vol_q <= data_byte_i;
        else if (pend_eff[3]) ev_cmd_q <= data_byte_i;
        else if (pend_eff[4]) ev_pf_q <= data_byte_i;
        else ev_ps_q <= data_byte_i;
      end else if (tok_ok && (data_byte_i[1:0] == TokEvent)) begin
        ev_note_q <= '0;
        ev_inst_q <= '0;
        ev_vol_q  <= '0;
        ev_cmd_q  <= '0;
        ev_pf_q   <= '0;
        ev_ps_q   <= '0;
      end
    end
  end

  // output word register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (emit) begin
      out_vld_q <= 1'b1;
    end else if (m_tready_i) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      out_row_q  <= 8'(rc_q);
      out_cell_q <= emit_cell;
      out_last_q <= cmd_i.emit_evt || sts_o.row_last;
    end
  end

  assign m_tvalid_o  = out_vld_q;
  assign row_index_o = out_row_q;
  assign cell_o      = out_cell_q;
  assign last_o      = out_last_q;

endmodule

// File: design/tracker_track_row_decoder.sv
// Top level of the track row decoder: stream ports, register port, controller and datapath.
//
// Input stream: one compressed track byte per word, s_axis_tdata[7:0]; s_axis_tuser
// marks the first byte of a track, which clears the cell store, the row count and
// any open event before the byte is decoded.
// Output stream: one decoded row per word; m_axis_tlast marks the last row that an
// input byte causes.
// Register port: rows_in_pattern at byte address 0 (9 bits, reset 64).
// Sequencing: a byte that emits nothing (skip, event byte, ignored byte) is taken in
// S_IN, and the controller stays ready for the next byte. A completed event moves to
// S_EVT, which loads its row into the output register, and the input is held there.
// A run or copy passes through S_RD (cell store read) and S_WR (write back and output
// load) for each row, and the input is held until its last row is loaded. S_RD is
// there for the registered read of the cell store.
// Reset: the cell store reads as empty at once (per-row valid bits), so no clearing
// pass is needed, neither after reset nor at a track start.
// Stall: results sit in one output register; while it is full and the receiver holds
// tready low, row emission waits; bytes are still taken while the controller is in S_IN.
module tracker_track_row_decoder #(
  parameter int unsigned MAX_ROWS = trd_pkg::DefMaxRows
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // register port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  // input words
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
  input  logic        s_axis_tuser,   // [0] track_start
  // output words
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [47:0] m_axis_tdata,   // row_index, note, instrument, has_volume, volume,
                                      // effect_code, effect_param, zero pad
  output logic        m_axis_tlast    // last_of_run
);
  import trd_pkg::*;

  localparam logic RegRows = 1'b0;

  logic [CfgW-1:0] rows_q;
  trd_cmd_t        cmd;
  trd_sts_t        sts;
  cell_t           row_cell;
  logic [7:0]      row_index;

  // configuration register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rows_q <= CfgW'(CfgReset);
    end else if (psel && penable && pwrite && pready && (paddr[2] == RegRows) &&
                 (paddr[1:0] == 2'b00)) begin
      rows_q <= pwdata[CfgW-1:0];
    end
  end

  assign pready = 1'b1;
  assign prdata = ((paddr[2] == RegRows) && (paddr[1:0] == 2'b00)) ? 32'(rows_q) : 32'd0;

  trd_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_tvalid_i(s_axis_tvalid),
    .s_tready_o(s_axis_tready),
    .sts_i     (sts),
    .cmd_o     (cmd)
  );

  trd_dp #(
    .MAX_ROWS(MAX_ROWS)
  ) u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .rows_in_pattern_i(rows_q),
    .data_byte_i      (s_axis_tdata),
    .track_start_i    (s_axis_tuser),
    .cmd_i            (cmd),
    .sts_o            (sts),
    .m_tready_i       (m_axis_tready),
    .m_tvalid_o       (m_axis_tvalid),
    .row_index_o      (row_index),
    .cell_o           (row_cell),
    .last_o           (m_axis_tlast)
  );

  assign m_axis_tdata = {3'b000, row_cell.effect_param, row_cell.effect_code,
                         row_cell.volume, row_cell.has_volume, row_cell.instrument,
                         row_cell.note, row_index};

endmodule

// File: design/trd_checker.sv
// Port-level checker for the track row decoder and its bind to the top level.
module trd_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [47:0] m_axis_tdata,
  input logic        m_axis_tlast
);

  // a stalled output word holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("output word changed under stall");

  // no byte is taken while a run still has rows to give
  a_run_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tlast |-> !s_axis_tready)
    else $error("input taken in the middle of a run");

  // no effect means no parameter
  a_eff_param: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tdata[36:32] == 5'd0) |-> (m_axis_tdata[44:37] == 8'd0))
    else $error("parameter without effect");

  // no volume flag means zero volume
  a_vol: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tdata[24] |-> (m_axis_tdata[31:25] == 7'd0))
    else $error("volume without flag");

endmodule

bind tracker_track_row_decoder trd_checker u_trd_checker (.*);
